### src/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit
// used by rau_ctrl, rau_datapath and rational_arithmetic_unit; no dependencies
`timescale 1ns / 1ps

package rau_pkg;

  // operation selector codes
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEN_ZERO = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_AN_FB = 3'd0,
    MUL_BN_FA = 3'd1,
    MUL_AD_FA = 3'd2,
    MUL_AN_BN = 3'd3,
    MUL_AD_BD = 3'd4,
    MUL_AN_BD = 3'd5,
    MUL_AD_BN = 3'd6
  } mul_sel_t;

  // which scale factor the divider produces
  typedef enum logic {
    DIV_FA = 1'b0,
    DIV_FB = 1'b1
  } div_sel_t;

  // how the result numerator is formed
  typedef enum logic [1:0] {
    NUM_PROD = 2'd0,
    NUM_SUM  = 2'd1,
    NUM_DIFF = 2'd2
  } num_mode_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_FA_START,
    S_FA_WAIT,
    S_FB_WAIT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_PROD1,
    S_PROD2,
    S_PROD3,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      gcd_step;
    logic      g_load;
    logic      div_start;
    div_sel_t  div_sel;
    logic      fa_load;
    logic      fb_load;
    mul_sel_t  mul_sel;
    logic      acc_load;
    logic      num_load;
    num_mode_t num_mode;
    logic      den_load;
    logic      res_clear;
    logic      stat_load;
    status_t   stat_code;
  } rau_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic    den_zero;
    logic    div_zero;
    action_t op;
    logic    gcd_done;
    logic    div_busy;
  } rau_sts_t;

endpackage

### src/rau_ctrl.sv
// rau_ctrl: sequencing state machine of the rational arithmetic unit
// depends on rau_pkg; drives rau_datapath through rau_cmd_t
`timescale 1ns / 1ps

module rau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rau_pkg::rau_sts_t sts,
  output rau_pkg::rau_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import rau_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel  = MUL_AN_FB;
    cmd.div_sel  = DIV_FA;
    cmd.num_mode = NUM_PROD;
    cmd.stat_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.stat_load = 1'b1;
        priority if (sts.den_zero) begin
          cmd.res_clear = 1'b1;
          cmd.stat_code = ST_DEN_ZERO;
          state_next    = S_DONE;
        end else if (sts.op == ACT_DIV && sts.div_zero) begin
          cmd.res_clear = 1'b1;
          cmd.stat_code = ST_DIV_ZERO;
          state_next    = S_DONE;
        end else if (sts.op == ACT_ADD || sts.op == ACT_SUB) begin
          state_next = S_GCD;
        end else begin
          state_next = S_PROD1;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.g_load = 1'b1;
          state_next = S_FA_START;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_FA_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FA;
        state_next    = S_FA_WAIT;
      end
      S_FA_WAIT: begin
        if (!sts.div_busy) begin
          cmd.fa_load   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FB;
          state_next    = S_FB_WAIT;
        end
      end
      S_FB_WAIT: begin
        if (!sts.div_busy) begin
          cmd.fb_load = 1'b1;
          state_next  = S_MUL1;
        end
      end
      // scaled numerators and common denominator through one multiplier
      S_MUL1: begin
        cmd.mul_sel = MUL_AN_FB;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_sel  = MUL_BN_FA;
        cmd.acc_load = 1'b1;
        state_next   = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_sel  = MUL_AD_FA;
        cmd.num_load = 1'b1;
        cmd.num_mode = (sts.op == ACT_SUB) ? NUM_DIFF : NUM_SUM;
        state_next   = S_MUL4;
      end
      S_MUL4: begin
        cmd.den_load = 1'b1;
        state_next   = S_DONE;
      end
      // direct products for multiply, cross products for divide
      S_PROD1: begin
        cmd.mul_sel = (sts.op == ACT_DIV) ? MUL_AN_BD : MUL_AN_BN;
        state_next  = S_PROD2;
      end
      S_PROD2: begin
        cmd.mul_sel  = (sts.op == ACT_DIV) ? MUL_AD_BN : MUL_AD_BD;
        cmd.num_load = 1'b1;
        cmd.num_mode = NUM_PROD;
        state_next   = S_PROD3;
      end
      S_PROD3: begin
        cmd.den_load = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

### src/rau_datapath.sv
// rau_datapath: operand registers, binary gcd, restoring divider, shared multiplier
// depends on rau_pkg; controlled by rau_ctrl through rau_cmd_t
`timescale 1ns / 1ps

module rau_datapath #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rau_pkg::rau_cmd_t       cmd,
  output rau_pkg::rau_sts_t       sts,
  input  rau_pkg::action_t        action,
  input  logic [OPERAND_WIDTH-1:0] a_num,
  input  logic [OPERAND_WIDTH-2:0] a_den,
  input  logic [OPERAND_WIDTH-1:0] b_num,
  input  logic [OPERAND_WIDTH-2:0] b_den,
  output logic [31:0]             res_num,
  output logic [30:0]             res_den,
  output rau_pkg::status_t        status
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = OPERAND_WIDTH - 1;
  localparam int CW = $clog2(OPERAND_WIDTH);

  // latched operands
  action_t         op;
  logic [W-1:0]    an, bn;
  logic [DW-1:0]   ad, bd;

  // gcd, divider and scale factor registers
  logic [DW-1:0]   gx, gy, gx_next, gy_next, g;
  logic [CW-1:0]   gk, gk_next;
  logic [DW-1:0]   dq, rem, dvs, fa, fb;
  logic [CW-1:0]   dcnt;

  // multiplier and result registers
  logic [31:0]     prod, acc, mul_a, mul_b;
  logic [31:0]     num_reg;
  logic [30:0]     den_reg;
  status_t         stat_reg;

  logic            gcd_done;
  logic [DW-1:0]   gcd_val;
  logic [DW:0]     trial, diff;
  logic            ge;
  logic [31:0]     an_x, bn_x, ad_x, bd_x, fa_x, fb_x;

  // operand capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= action;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
  end

  // binary gcd, one step per cycle
  assign gcd_done = (gx == '0) || (gy == '0);
  assign gcd_val  = DW'((gx | gy) << gk);

  always_comb begin
    gx_next = gx;
    gy_next = gy;
    gk_next = gk;
    if (cmd.load) begin
      gx_next = a_den;
      gy_next = b_den;
      gk_next = '0;
    end else if (cmd.gcd_step && !gcd_done) begin
      priority if (!gx[0] && !gy[0]) begin
        gx_next = gx >> 1;
        gy_next = gy >> 1;
        gk_next = gk + CW'(1);
      end else if (!gx[0]) begin
        gx_next = gx >> 1;
      end else if (!gy[0]) begin
        gy_next = gy >> 1;
      end else if (gx >= gy) begin
        gx_next = (gx - gy) >> 1;
      end else begin
        gy_next = (gy - gx) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    gx <= gx_next;
    gy <= gy_next;
    gk <= gk_next;
    if (cmd.g_load) begin
      g <= gcd_val;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, dq[DW-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= CW'(DW);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq  <= (cmd.div_sel == DIV_FA) ? bd : ad;
      rem <= '0;
      dvs <= g;
    end else if (dcnt != '0) begin
      dq  <= {dq[DW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
    if (cmd.fa_load) begin
      fa <= dq;
    end
    if (cmd.fb_load) begin
      fb <= dq;
    end
  end

  // shared multiplier, low 32 bits of the product
  assign an_x = 32'($signed(an));
  assign bn_x = 32'($signed(bn));
  assign ad_x = 32'(ad);
  assign bd_x = 32'(bd);
  assign fa_x = 32'(fa);
  assign fb_x = 32'(fb);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_AN_FB: begin mul_a = an_x; mul_b = fb_x; end
      MUL_BN_FA: begin mul_a = bn_x; mul_b = fa_x; end
      MUL_AD_FA: begin mul_a = ad_x; mul_b = fa_x; end
      MUL_AN_BN: begin mul_a = an_x; mul_b = bn_x; end
      MUL_AD_BD: begin mul_a = ad_x; mul_b = bd_x; end
      MUL_AN_BD: begin mul_a = an_x; mul_b = bd_x; end
      MUL_AD_BN: begin mul_a = ad_x; mul_b = bn_x; end
      default:   begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.acc_load) begin
      acc <= prod;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      num_reg <= '0;
      den_reg <= '0;
    end else begin
      if (cmd.num_load) begin
        unique case (cmd.num_mode)
          NUM_PROD: num_reg <= prod;
          NUM_SUM:  num_reg <= acc + prod;
          NUM_DIFF: num_reg <= acc - prod;
          default:  num_reg <= prod;
        endcase
      end
      if (cmd.den_load) begin
        den_reg <= prod[30:0];
      end
    end
    if (cmd.stat_load) begin
      stat_reg <= cmd.stat_code;
    end
  end

  // status to controller
  assign sts.den_zero = (ad == '0) || (bd == '0);
  assign sts.div_zero = (bn == '0);
  assign sts.op       = op;
  assign sts.gcd_done = gcd_done;
  assign sts.div_busy = (dcnt != '0);

  assign res_num = num_reg;
  assign res_den = den_reg;
  assign status  = stat_reg;

endmodule

### src/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level, fraction add, subtract, multiply and divide
// depends on rau_pkg, rau_ctrl and rau_datapath
//
// channel   direction  ports                                        transfer
// command   in         start, action, a_num, a_den, b_num, b_den    start && !busy
// result    out        done, res_num, res_den, status               done (one cycle)
//
// add/subtract: a check state, at most 2*(W-1)-1 binary gcd steps plus a final
//   gcd state, a divider start state, two restoring divisions of W-1 quotient
//   bits each, four multiplier states and the result state that gives the strobe
// multiply/divide: a check state, three product states and the result state;
//   zero denominator or divide by zero: the check state, then the result state;
//   the controller returns to idle after each strobe
// rst is synchronous and returns the controller to idle; busy stays high until
//   the result cycle ends, and the result cannot be held off by the receiver
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  rau_pkg::action_t         action,
  input  logic [OPERAND_WIDTH-1:0] a_num,
  input  logic [OPERAND_WIDTH-2:0] a_den,
  input  logic [OPERAND_WIDTH-1:0] b_num,
  input  logic [OPERAND_WIDTH-2:0] b_den,
  output logic                     done,
  output logic [31:0]              res_num,
  output logic [30:0]              res_den,
  output rau_pkg::status_t         status
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;

  // sequencing
  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic
  rau_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .action  (action),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .res_num (res_num),
    .res_den (res_den),
    .status  (status)
  );

  // a result only appears while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a command");

  // a transfer never produces a result in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("command transfer not followed by busy");

  // one strobe per command
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // error results carry a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (res_num == '0 && res_den == '0))
    else $error("error result with nonzero fraction");

endmodule
